@@ rtl/core/ptcf_pkg.sv @@
// Shared constants, result codes and controller/datapath interface types.
package ptcf_pkg;

  localparam int SLOTS        = 64;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int POS_W        = CNT_W + 1;
  localparam int PAGE_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int SLOT_FIELD_W = 6;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 48;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT  = 2'd0,
    STATUS_FILL = 2'd1,
    STATUS_ERR  = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the incoming request
    logic take_free;  // victim is the lowest empty slot
    logic evict;      // victim is the queue head: pop it, drop its valid bit
    logic emit_hit;   // load a hit result
    logic emit_err;   // load an error result without fill (store full, queue empty)
    logic fill;       // commit the fill (unless read error) and load its result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic any_free;
    logic ring_empty;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/page_tag_cache_fifo_replacement.sv @@
// Top level of the fully associative page tag cache with FIFO replacement.
//
// Each request carries a page index and a read-error flag. All 64 tags are
// compared in parallel; a hit returns the lowest matching slot. A miss takes
// the lowest empty slot, or else evicts the oldest filled slot (head of the
// fill-order queue) and reports its page. The chosen slot is then filled and
// queued, unless the request flags a read error: then the slot stays empty,
// status is 2 and slot is 0 (an eviction already made is still reported).
// Hits never reorder the queue. One request is in work at a time: a hit goes
// through accept and compare; a miss adds a fill step, an eviction also an
// evict step before it for the registered read of the evicted page from the
// tag copy RAM, addressed by the slot at the queue head. A step that loads a
// result waits while out_tready stalls a held result. The result register
// lets the next request be taken while a result waits. The valid bits clear
// at reset; no clearing pass is needed.
module page_tag_cache_fifo_replacement
  import ptcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] page_index, [32] read_error
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [1:0] status, [7:2] slot, [8] evicted,
                                            // [40:9] evicted_page
);

  cmd_t                    cmd;
  stat_t                   stat;
  logic [STATUS_W-1:0]     res_status;
  logic [SLOT_FIELD_W-1:0] res_slot;
  logic                    res_evicted;
  logic [PAGE_W-1:0]       res_page;

  ptcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptcf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_page          (in_tdata[PAGE_W-1:0]),
    .in_err           (in_tdata[PAGE_W]),
    .cmd              (cmd),
    .stat             (stat),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_status       (res_status),
    .out_slot         (res_slot),
    .out_evicted      (res_evicted),
    .out_evicted_page (res_page)
  );

  // pack result fields, lowest first, zero-filled to whole bytes
  assign out_tdata = OUT_DATA_W'({res_page, res_evicted, res_slot, res_status});

endmodule

@@ rtl/core/ptcf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ptcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/ptcf_ctrl.sv @@
// Request sequencer: lookup, optional eviction, fill and result hand-off.
module ptcf_ctrl
  import ptcf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_EVICT  = 4'b0100,
    S_FILL   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat.hit) begin
          if (stat.out_free) begin
            cmd.emit_hit = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (stat.any_free) begin
          cmd.take_free = 1'b1;
          state_nxt     = S_FILL;
        end else if (stat.ring_empty) begin
          if (stat.out_free) begin
            cmd.emit_err = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (stat.out_free) begin
          cmd.fill  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/ptcf_dp.sv @@
// Tag compare array, valid bits, fill-order queue, tag copy RAM and result register.
module ptcf_dp
  import ptcf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [PAGE_W-1:0]       in_page,
  input  logic                    in_err,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_FIELD_W-1:0] out_slot,
  output logic                    out_evicted,
  output logic [PAGE_W-1:0]       out_evicted_page
);

  // request
  logic [PAGE_W-1:0] page_r;
  logic              err_r;

  // lookup array
  logic [PAGE_W-1:0] tags_r [SLOTS];
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  hit_vec;
  logic [SLOT_W-1:0] hit_slot, free_slot;

  // fill-order queue
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] ring_rdata, ring_slot, ring_waddr;
  logic [POS_W-1:0]  ring_pos;
  logic              ring_we;

  // victim and tag copy
  logic [SLOT_W-1:0] victim_r;
  logic              evicted_r;
  logic [SLOT_W-1:0] tag_raddr;
  logic [PAGE_W-1:0] tag_rdata;
  logic              fill_we;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic [SLOT_FIELD_W-1:0] out_slot_r;
  logic                    out_evicted_r;
  logic [PAGE_W-1:0]       out_page_r;
  logic                    out_load;

  // parallel compare and lowest-index priority encoders
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (tags_r[i] == page_r);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // a queue entry out of range falls back to slot 0
  assign ring_slot = (CNT_W'(ring_rdata) >= CNT_W'(SLOTS)) ? '0 : ring_rdata;

  assign ring_pos   = POS_W'(head_r) + POS_W'(count_r);
  assign ring_waddr = (ring_pos >= POS_W'(SLOTS)) ? SLOT_W'(ring_pos - POS_W'(SLOTS))
                                                  : SLOT_W'(ring_pos);
  assign fill_we    = cmd.fill && !err_r;
  assign ring_we    = fill_we && (count_r < CNT_W'(SLOTS));
  assign tag_raddr  = cmd.evict ? ring_slot : victim_r;

  assign stat.hit        = |hit_vec;
  assign stat.any_free   = ~&valid_r;
  assign stat.ring_empty = (count_r == '0);
  assign stat.out_free   = !out_valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.evict) begin
      valid_nxt[ring_slot] = 1'b0;
      head_nxt  = (head_r == SLOT_W'(SLOTS - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (fill_we) begin
      valid_nxt[victim_r] = 1'b1;
    end
    if (ring_we) begin
      count_nxt = count_r + 1'b1;
    end
  end

  assign out_load = cmd.emit_hit || cmd.emit_err || cmd.fill;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_page;
      err_r  <= in_err;
    end
    if (fill_we) begin
      tags_r[victim_r] <= page_r;
    end
    if (cmd.take_free) begin
      victim_r  <= free_slot;
      evicted_r <= 1'b0;
    end else if (cmd.evict) begin
      victim_r  <= ring_slot;
      evicted_r <= 1'b1;
    end
    if (cmd.emit_hit) begin
      out_status_r  <= STATUS_HIT;
      out_slot_r    <= SLOT_FIELD_W'(hit_slot);
      out_evicted_r <= 1'b0;
      out_page_r    <= '0;
    end else if (cmd.emit_err) begin
      out_status_r  <= STATUS_ERR;
      out_slot_r    <= '0;
      out_evicted_r <= 1'b0;
      out_page_r    <= '0;
    end else if (cmd.fill) begin
      out_status_r  <= err_r ? STATUS_ERR : STATUS_FILL;
      out_slot_r    <= err_r ? '0 : SLOT_FIELD_W'(victim_r);
      out_evicted_r <= evicted_r;
      out_page_r    <= evicted_r ? tag_rdata : '0;
    end
  end

  ptcf_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (victim_r),
    .rd_addr (head_r),
    .rd_data (ring_rdata)
  );

  // copy of the tag array, read only to report the evicted page
  ptcf_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (victim_r),
    .wr_data (page_r),
    .rd_addr (tag_raddr),
    .rd_data (tag_rdata)
  );

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_page_r;

endmodule

@@ bench/page_tag_cache_fifo_replacement_checker.sv @@
// Checker for the page tag cache: tracks requests, predicts results, compares them.
`timescale 1ns / 100ps

module page_tag_cache_fifo_replacement_checker
  import ptcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] page_index, [32] read_error
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] status, [7:2] slot, [8] evicted,
                                            // [40:9] evicted_page
  input  logic                  done,
  output int                    fail_count,
  output int                    hit_count,
  output int                    fill_count,
  output int                    err_count,
  output int                    evict_count
);

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    evicted;
    logic [PAGE_W-1:0]       evicted_page;
  } lookup_t;

  // shadow copy of the tag store and fill-order queue
  logic [PAGE_W-1:0] shadow_tag [SLOTS];
  logic              shadow_valid [SLOTS];
  logic [SLOT_W-1:0] shadow_ring [SLOTS];
  logic [SLOT_W-1:0] shadow_head;
  logic [CNT_W-1:0]  shadow_count;

  lookup_t pending_lookups[$];
  bit      leftover_checked;

  function automatic lookup_t predict_lookup(logic [PAGE_W-1:0] page, logic rd_err);
    lookup_t           res;
    logic [SLOT_W-1:0] victim;
    bit                have_free;
    res       = '{status: STATUS_HIT, slot: '0, evicted: 1'b0, evicted_page: '0};
    victim    = '0;
    have_free = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_tag[i] == page) begin
        res.slot = SLOT_FIELD_W'(i);
        return res;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!have_free && !shadow_valid[i]) begin
        victim    = SLOT_W'(i);
        have_free = 1'b1;
      end
    end
    if (!have_free) begin
      if (shadow_count == 0) begin
        res.status = STATUS_ERR;
        return res;
      end
      victim               = shadow_ring[shadow_head];
      shadow_head          = shadow_head + 1'b1;
      shadow_count         = shadow_count - 1'b1;
      res.evicted          = 1'b1;
      res.evicted_page     = shadow_tag[victim];
      shadow_valid[victim] = 1'b0;
    end
    if (rd_err) begin
      res.status = STATUS_ERR;
      return res;
    end
    shadow_tag[victim]   = page;
    shadow_valid[victim] = 1'b1;
    if (shadow_count < SLOTS) begin
      shadow_ring[SLOT_W'(shadow_head + shadow_count)] = victim;
      shadow_count = shadow_count + 1'b1;
    end
    res.status = STATUS_FILL;
    res.slot   = SLOT_FIELD_W'(victim);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch: %s got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    lookup_t want;
    lookup_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        shadow_valid[i] = 1'b0;
      end
      shadow_head  = '0;
      shadow_count = '0;
      pending_lookups.delete();
    end else begin
      // result side first: a result never belongs to a request taken at the same edge
      if (out_tvalid && out_tready) begin
        got = '{status: status_t'(out_tdata[1:0]), slot: out_tdata[7:2],
                evicted: out_tdata[8], evicted_page: out_tdata[40:9]};
        if (pending_lookups.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = pending_lookups.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.slot != want.slot)
            report_mismatch("slot", got.slot, want.slot);
          if (got.evicted != want.evicted)
            report_mismatch("evicted", got.evicted, want.evicted);
          if (got.evicted_page != want.evicted_page)
            report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_lookup(in_tdata[31:0], in_tdata[32]);
        case (want.status)
          STATUS_HIT:  hit_count++;
          STATUS_FILL: fill_count++;
          default:     err_count++;
        endcase
        if (want.evicted) evict_count++;
        pending_lookups.push_back(want);
      end
      if (done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_lookups.size() != 0)
          report_mismatch("results never delivered", pending_lookups.size(), 0);
      end
    end
  end

endmodule

@@ bench/page_tag_cache_fifo_replacement_tb.sv @@
// Testbench top for the page tag cache: clock, reset, request/result traffic, verdict.
`timescale 1ns / 100ps

module page_tag_cache_fifo_replacement_tb;
  import ptcf_pkg::*;

  localparam int SEGMENTS     = 14;
  localparam int SEG_ITEMS    = 100;
  localparam int POOL_DEPTH   = 128;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] page_index, [32] read_error
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [1:0] status, [7:2] slot, [8] evicted,
                                     // [40:9] evicted_page
  logic                  done;

  int fail_count, hit_count, fill_count, err_count, evict_count;
  int sent_count, recv_count;

  // shared knobs between the request and result processes
  bit no_idle;      // both sides run back to back
  int hold_cycles;  // receiver holds off this long before its next result

  logic [PAGE_W-1:0] page_pool [POOL_DEPTH];

  page_tag_cache_fifo_replacement u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  page_tag_cache_fifo_replacement_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .done        (done),
    .fail_count  (fail_count),
    .hit_count   (hit_count),
    .fill_count  (fill_count),
    .err_count   (err_count),
    .evict_count (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // handshake counts, used to know when everything in flight has come back
  always @(posedge clk) begin
    if (in_tvalid && in_tready) sent_count++;
    if (out_tvalid && out_tready) recv_count++;
  end

  // hard stop; the slowest legal run is well under a tenth of this
  initial begin
    #2_000_000;
    $display("** page_tag_cache_fifo_replacement: FAILED **");
    $finish;
  end

  // One request: optional idle gap, then hold valid until the block takes it.
  // Called right after a rising edge; returns at the edge of acceptance.
  task automatic send_request(logic [PAGE_W-1:0] page, logic rd_err);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, rd_err, page};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drop valid first so the last request is not offered again while waiting
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (recv_count != sent_count) @(posedge clk);
  endtask

  // Result side: a random hold-off per result, plus the long stall on request.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        // long back-pressure: the block fills up and drops in_tready
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int                pool_used;
    int                err_odds;
    logic [PAGE_W-1:0] page;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    done        <= 1'b0;
    no_idle     = 1'b0;
    hold_cycles = 0;
    for (int i = 0; i < POOL_DEPTH; i++) page_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, hit ignoring read error, miss with read error
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0000, 1'b1);   // hit: read error must be ignored
    send_request(32'h5555_5555, 1'b1);   // miss, read error: slot stays empty
    send_request(32'h5555_5555, 1'b0);   // same page again now fills
    send_request(32'hAAAA_AAAA, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);   // hit on the all-ones tag
    send_request(32'h5555_5555, 1'b0);
    send_request(32'h0000_0001, 1'b1);

    // seven tags are live; 57 fresh pages fill the store to the brim
    for (int i = 0; i < 57; i++) send_request($urandom, 1'b0);
    send_request($urandom, 1'b1);        // evicts the oldest, then read error
    send_request($urandom, 1'b0);        // lands in the slot just freed
    send_request($urandom, 1'b0);        // evicts again
    send_request(32'h0000_0000, 1'b0);   // oldest tag has been evicted: miss

    // random segments, each with its own locality, error rate and idling
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 3))
        0:       pool_used = 40;          // fits in the store: mostly hits
        1:       pool_used = 72;          // just over capacity: steady eviction
        2:       pool_used = POOL_DEPTH;
        default: pool_used = 0;           // fully random pages: nearly all misses
      endcase
      case ($urandom_range(0, 2))
        0:       err_odds = 0;
        1:       err_odds = 8;
        default: err_odds = 2;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      // refresh part of the pool so old tags age out
      for (int i = 0; i < 16; i++) page_pool[$urandom_range(0, POOL_DEPTH - 1)] = $urandom;

      if (seg == 3) hold_cycles = LONG_HOLD;   // sender keeps offering meanwhile
      if (seg == 6) wait_drained();            // sender pauses until all results are in

      for (int k = 0; k < SEG_ITEMS; k++) begin
        page = (pool_used == 0) ? $urandom : page_pool[$urandom_range(0, pool_used - 1)];
        send_request(page, (err_odds != 0) && ($urandom_range(1, err_odds) == 1));
      end
    end
    in_tvalid <= 1'b0;
    no_idle   = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run covered %0d requests: %0d hits, %0d fills, %0d read-error misses,",
             sent_count, hit_count, fill_count, err_count);
    $display("  %0d FIFO evictions, one long result stall and one full drain mid-run",
             evict_count);
    if (fail_count == 0) begin
      $display("** page_tag_cache_fifo_replacement: PASSED **");
    end else begin
      $display("** page_tag_cache_fifo_replacement: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ptcf_pkg.sv
rtl/core/ptcf_ram.sv
rtl/core/ptcf_ctrl.sv
rtl/core/ptcf_dp.sv
rtl/core/page_tag_cache_fifo_replacement.sv
bench/page_tag_cache_fifo_replacement_checker.sv
bench/page_tag_cache_fifo_replacement_tb.sv
